>>> rtl/pcxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX decoder package
// Register indexes, input codes and the types shared by the decoder modules.
// ----------------------------------------------------------------------------
package pcxd_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PLANE_BYTES  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLOR_MODE   = 2'd3;

    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_CODE    = 1'b1;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_RGB     = 1'b1;

    // Both top bits set marks a run header.
    localparam logic [1:0] RUN_TAG = 2'b11;

    localparam logic [1:0] PLANE_RED   = 2'd0;
    localparam logic [1:0] PLANE_GREEN = 2'd1;
    localparam logic [1:0] PLANE_BLUE  = 2'd2;

    localparam int PAL_AW = 8;
    localparam int PAL_DEPTH = 256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       image_end;
    } t_pixel;

    typedef struct packed {
        logic       visible;
        logic       row_end;
        logic       image_end;
        logic       line_done;
        logic [1:0] plane;
    } t_scan_info;

endpackage

>>> rtl/pcxd_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX decoder color table
// 256-entry RGB palette, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcxd_palette (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [pcxd_pkg::PAL_AW-1:0] i_waddr,
    input  logic [23:0]               i_wdata,
    input  logic                      i_re,
    input  logic [pcxd_pkg::PAL_AW-1:0] i_raddr,
    output logic [23:0]               o_rdata
);
    import pcxd_pkg::*;

    logic [23:0] r_mem [0:PAL_DEPTH-1];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pcxd_linebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX decoder line buffer
// Holds the red and green bytes of one scanline, with a write enable per byte.
// ----------------------------------------------------------------------------
module pcxd_linebuf #(
    parameter int MAX_LINE_BYTES = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_we_red,
    input  logic                              i_we_green,
    input  logic                              i_re,
    input  logic [$clog2(MAX_LINE_BYTES)-1:0] i_addr,
    input  logic [7:0]                        i_wdata,
    output logic [15:0]                       o_rdata
);
    logic [15:0] r_mem [0:MAX_LINE_BYTES-1];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we_red) begin
            r_mem[i_addr][15:8] <= i_wdata;
        end
        if (i_we_green) begin
            r_mem[i_addr][7:0] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pcxd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX decoder scan position
// Column, plane and row counters with the compare unit that decides
// visibility, row and image end, and where the next scanline byte lands.
// ----------------------------------------------------------------------------
module pcxd_scan #(
    parameter int MAX_LINE_BYTES = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [11:0]                       i_image_width,
    input  logic [15:0]                       i_image_height,
    input  logic [11:0]                       i_plane_bytes,
    input  logic                              i_color_mode,
    output logic [$clog2(MAX_LINE_BYTES)-1:0] o_column,
    output pcxd_pkg::t_scan_info              o_info
);
    import pcxd_pkg::*;

    localparam int CW = $clog2(MAX_LINE_BYTES);
    localparam int PW = (CW + 1 > 12) ? CW + 1 : 12;

    logic [CW-1:0] r_column;
    logic [1:0]    r_plane;
    logic [15:0]   r_row;

    logic [PW-1:0] pb;
    logic [PW-1:0] effp;
    logic [PW-1:0] effw;
    logic [PW-1:0] col_ext;
    logic [PW-1:0] col_inc;
    logic [15:0]   row_inc;
    logic          last_row;
    logic          col_wrap;
    logic          vis;
    logic          rend;
    logic          line_done;

    assign pb = PW'(i_plane_bytes);

    // A plane size of zero acts as one; larger than the buffer saturates.
    always_comb begin
        if (pb == '0) begin
            effp = PW'(1);
        end else if (pb > PW'(MAX_LINE_BYTES)) begin
            effp = PW'(MAX_LINE_BYTES);
        end else begin
            effp = pb;
        end
    end

    assign effw      = (PW'(i_image_width) < effp) ? PW'(i_image_width) : effp;
    assign col_ext   = PW'(r_column);
    assign col_inc   = col_ext + PW'(1);
    assign row_inc   = r_row + 16'd1;
    assign last_row  = (row_inc == i_image_height);
    assign vis       = (col_ext < effw);
    assign rend      = vis && (col_inc == effw);
    assign col_wrap  = !(col_inc < effp);
    assign line_done = col_wrap && ((i_color_mode == MODE_PALETTE) || (r_plane >= PLANE_BLUE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_plane  <= PLANE_RED;
            r_row    <= '0;
        end else if (i_step) begin
            if (!col_wrap) begin
                r_column <= col_inc[CW-1:0];
            end else begin
                r_column <= '0;
                if (line_done) begin
                    r_plane <= PLANE_RED;
                    r_row   <= last_row ? 16'd0 : row_inc;
                end else begin
                    r_plane <= r_plane + 2'd1;
                end
            end
        end
    end

    assign o_column          = r_column;
    assign o_info.visible    = vis;
    assign o_info.row_end    = rend;
    assign o_info.image_end  = rend && last_row;
    assign o_info.line_done  = line_done;
    assign o_info.plane      = r_plane;

endmodule

>>> rtl/pcx_scanline_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX scanline decoder
// Expands a PCX run-length byte stream into RGB pixels, through a palette in
// one-plane mode or from buffered red and green planes in three-plane mode.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one word per item: tuser selects a palette write
//   (index and color in tdata) or an encoded byte (code byte in tdata). The
//   master stream carries one pixel per word; tlast flags the last pixel of a
//   row, tuser flags image end and the last pixel caused by the input word.
//   Registers are written through the cfg port while the decoder is idle.
// Sequencing:
//   A palette write, a run header or the data byte of a zero-length run is
//   taken while the decoder stays idle. A literal byte passes through the emit
//   state once; a run that expands n bytes passes through it n times with a
//   read state between bytes, plus a flush state to release the held pixel
//   when any byte before the last one emitted. Every scanline byte costs one
//   read of the palette or line buffer and one pass through the position
//   compare unit. A literal's pixel is registered out of the emit state; inside
//   a run each pixel is held until the next byte shows whether it ends the
//   burst. The decoder takes no new word while a byte or run is being expanded.
// Reset and stalls:
//   Reset returns to row 0, column 0, plane 0 with no pending run and the
//   registers at width 1, height 1, plane size 1, palette mode. Palette and
//   line buffer contents are undefined until written. When the receiver
//   stalls, the pixel and the one held behind it wait and expansion pauses.
// ----------------------------------------------------------------------------
module pcx_scanline_decoder #(
    parameter int MAX_LINE_BYTES = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcxd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pcxd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // palette_index, palette_color, code_byte
    input  logic [39:0]                         s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // red, green, blue
    output logic [23:0]                         m_axis_tdata,
    output logic                                m_axis_tlast,
    // image_end, burst_last
    output logic [1:0]                          m_axis_tuser
);
    import pcxd_pkg::*;

    localparam int CW = $clog2(MAX_LINE_BYTES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_EMIT  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [11:0] r_image_width;
    logic [15:0] r_image_height;
    logic [11:0] r_plane_bytes;
    logic        r_color_mode;

    logic        r_run_waiting;
    logic [5:0]  r_run_len;
    logic [5:0]  r_left, n_left;
    logic [7:0]  r_byte;
    logic        r_pend_valid, n_pend_valid;
    t_pixel      r_pend, n_pend;
    logic        r_out_valid, n_out_valid;
    t_pixel      r_out, n_out;
    logic        r_out_last, n_out_last;

    logic [7:0]  in_index;
    logic [23:0] in_color;
    logic [7:0]  in_code;
    logic        accept;
    logic        code_acc;
    logic        start;

    logic [CW-1:0] column;
    t_scan_info    info;
    logic          step;
    logic [23:0]   pal_rdata;
    logic [15:0]   lb_rdata;
    logic          mem_re;
    logic          we_red;
    logic          we_green;

    logic          out_free;
    logic          emit_pix;
    logic          last;
    logic          stall;
    t_pixel        new_pix;

    assign in_index = s_axis_tdata[7:0];
    assign in_color = s_axis_tdata[31:8];
    assign in_code  = s_axis_tdata[39:32];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign code_acc      = accept && (s_axis_tuser == ACT_CODE);
    // A byte that is neither a run header nor a zero-length run's data does work.
    assign start = code_acc && (r_run_waiting ? (r_run_len != 6'd0)
                                              : (in_code[7:6] != RUN_TAG));

    assign mem_re = code_acc || (r_state == S_READ);

    pcxd_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (accept && (s_axis_tuser == ACT_PALETTE)),
        .i_waddr (in_index),
        .i_wdata (in_color),
        .i_re    (mem_re),
        .i_raddr ((r_state == S_IDLE) ? in_code : r_byte),
        .o_rdata (pal_rdata)
    );

    pcxd_linebuf #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_linebuf (
        .i_clk      (i_clk),
        .i_we_red   (we_red),
        .i_we_green (we_green),
        .i_re       (mem_re),
        .i_addr     (column),
        .i_wdata    (r_byte),
        .o_rdata    (lb_rdata)
    );

    pcxd_scan #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_plane_bytes  (r_plane_bytes),
        .i_color_mode   (r_color_mode),
        .o_column       (column),
        .o_info         (info)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign emit_pix = info.visible &&
                      ((r_color_mode == MODE_PALETTE) || (info.plane >= PLANE_BLUE));
    assign last     = (r_left == 6'd1) || info.line_done;
    // The newest pixel is held back until we know whether it ends the burst.
    assign stall    = emit_pix && (r_pend_valid || last) && !out_free;
    assign step     = (r_state == S_EMIT) && !stall;

    assign we_red   = step && (r_color_mode == MODE_RGB) && (info.plane == PLANE_RED);
    assign we_green = step && (r_color_mode == MODE_RGB) && (info.plane == PLANE_GREEN);

    always_comb begin
        if (r_color_mode == MODE_PALETTE) begin
            new_pix.red   = pal_rdata[23:16];
            new_pix.green = pal_rdata[15:8];
            new_pix.blue  = pal_rdata[7:0];
        end else begin
            new_pix.red   = lb_rdata[15:8];
            new_pix.green = lb_rdata[7:0];
            new_pix.blue  = r_byte;
        end
        new_pix.row_end   = info.row_end;
        new_pix.image_end = info.image_end;
    end

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out        = r_out;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_left  = r_run_waiting ? r_run_len : 6'd1;
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!stall) begin
                    n_left = r_left - 6'd1;
                    if (emit_pix) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_out_last  = 1'b0;
                        end else if (last) begin
                            n_out_valid = 1'b1;
                            n_out       = new_pix;
                            n_out_last  = 1'b1;
                        end
                        if (r_pend_valid || !last) begin
                            n_pend_valid = 1'b1;
                            n_pend       = new_pix;
                        end
                    end
                    if (!last) begin
                        n_state = S_READ;
                    end else if (n_pend_valid) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_run_waiting  <= 1'b0;
            r_run_len      <= '0;
            r_image_width  <= 12'd1;
            r_image_height <= 16'd1;
            r_plane_bytes  <= 12'd1;
            r_color_mode   <= MODE_PALETTE;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (code_acc) begin
                if (r_run_waiting) begin
                    r_run_waiting <= 1'b0;
                end else if (in_code[7:6] == RUN_TAG) begin
                    r_run_waiting <= 1'b1;
                    r_run_len     <= in_code[5:0];
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[11:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[15:0];
                    CFG_PLANE_BYTES:  r_plane_bytes  <= i_cfg_data[11:0];
                    CFG_COLOR_MODE:   r_color_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        if (start) begin
            r_byte <= in_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.blue, r_out.green, r_out.red};
    assign m_axis_tlast  = r_out.row_end;
    assign m_axis_tuser  = {r_out_last, r_out.image_end};

    // Nothing may be left behind when a new word is taken.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pend_valid)
        else $error("pending pixel left when decoder became ready");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_EMIT) |-> (r_left != 6'd0))
        else $error("byte expansion running with no bytes left");

    a_flush_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_pend_valid)
        else $error("flush state without a held pixel");

    a_palette_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser == ACT_PALETTE) |=> s_axis_tready)
        else $error("palette write did not complete in one cycle");

    a_zero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (code_acc && r_run_waiting && r_run_len == 6'd0)
            |=> (s_axis_tready && !r_run_waiting))
        else $error("zero-length run did not finish at once");

endmodule

>>> test/tb_pcx_scanline_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX scanline decoder testbench
// Feeds palette loads and encoded PCX bytes through the slave stream in random
// bursts. The pixel stream runs against a stalling receiver. Every input word
// that is accepted goes through a local decoder model, and each pixel that
// comes out is checked field by field against the oldest predicted pixel.
// Registers are reprogrammed between phases, covering both color modes,
// padded and clipped rows, zero-length runs and runs that cross a line end.
// ----------------------------------------------------------------------------
module tb_pcx_scanline_decoder;
    import pcxd_pkg::*;

    localparam int LINE_MAX = 2048;
    localparam int SETTLE_CYCLES = 150;

    typedef struct packed {
        logic        action;
        logic [7:0]  pal_idx;
        logic [23:0] pal_rgb;
        logic [7:0]  code;
    } t_stream_word;

    typedef struct packed {
        t_pixel px;
        logic   burst_last;
    } t_pixel_exp;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic [1:0]            m_axis_tuser;

    t_stream_word words_pending[$];
    t_pixel_exp   expected_pixels[$];
    int           mismatch_count = 0;

    // Decoder model state.
    logic [11:0] reg_width;
    logic [15:0] reg_height;
    logic [11:0] reg_plane;
    logic        reg_mode;
    logic        run_armed;
    logic [5:0]  run_count;
    logic [1:0]  plane_sel;
    logic [10:0] col_pos;
    logic [15:0] row_pos;
    logic [15:0] rg_buf [0:LINE_MAX-1];
    logic [23:0] pal_mem [0:PAL_DEPTH-1];

    // Sender and receiver pacing.
    int gap_left = 0;
    int burst_left = 1;
    int rx_left = 0;
    int hold_left = 0;
    int hold_req = 0;
    int hold_ack = 0;

    pcx_scanline_decoder #(
        .MAX_LINE_BYTES(LINE_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned eff_plane();
        int unsigned e;
        e = reg_plane;
        if (e == 0) e = 1;
        if (e > LINE_MAX) e = LINE_MAX;
        return e;
    endfunction

    // One scanline byte; line_done is set when the whole scanline is complete.
    task automatic place_byte(input logic [7:0] v, output bit line_done);
        int unsigned effp, effw;
        bit          visible, rend, iend, show;
        logic [15:0] rg;
        logic [23:0] color;
        t_pixel_exp  p;
        effp = eff_plane();
        effw = (reg_width < effp) ? reg_width : effp;
        visible = col_pos < effw;
        rend = visible && (col_pos + 1 == effw);
        iend = rend && (16'(row_pos + 16'd1) == reg_height);
        show = 1'b0;
        color = '0;
        line_done = 1'b0;
        if (reg_mode == MODE_PALETTE) begin
            show = visible;
            color = pal_mem[v];
        end else begin
            rg = rg_buf[col_pos];
            if (plane_sel == PLANE_RED) begin
                rg_buf[col_pos] = {v, rg[7:0]};
            end else if (plane_sel == PLANE_GREEN) begin
                rg_buf[col_pos] = {rg[15:8], v};
            end else begin
                show = visible;
                color = {rg, v};
            end
        end
        if (show) begin
            p.px.red = color[23:16];
            p.px.green = color[15:8];
            p.px.blue = color[7:0];
            p.px.row_end = rend;
            p.px.image_end = iend;
            p.burst_last = 1'b0;
            expected_pixels.push_back(p);
        end
        if (col_pos + 1 < effp) begin
            col_pos = col_pos + 11'd1;
        end else begin
            col_pos = '0;
            // A stale plane number in palette mode still ends the line here.
            if (reg_mode == MODE_PALETTE || plane_sel >= PLANE_BLUE) begin
                plane_sel = PLANE_RED;
                row_pos = (16'(row_pos + 16'd1) == reg_height) ? 16'd0 : row_pos + 16'd1;
                line_done = 1'b1;
            end else begin
                plane_sel = plane_sel + 2'd1;
            end
        end
    endtask

    task automatic decode_word(input logic action, input logic [7:0] idx,
                               input logic [23:0] rgb, input logic [7:0] code);
        int         first;
        int         i;
        bit         done;
        t_pixel_exp p;
        first = expected_pixels.size();
        if (action == ACT_PALETTE) begin
            pal_mem[idx] = rgb;
        end else if (run_armed) begin
            run_armed = 1'b0;
            for (i = 0; i < run_count; i++) begin
                place_byte(code, done);
                if (done) break;
            end
        end else if (code[7:6] == RUN_TAG) begin
            run_armed = 1'b1;
            run_count = code[5:0];
        end else begin
            place_byte(code, done);
        end
        if (expected_pixels.size() > first) begin
            p = expected_pixels.pop_back();
            p.burst_last = 1'b1;
            expected_pixels.push_back(p);
        end
    endtask

    // Register writes and accepted words update the model at the same edge
    // at which the decoder takes them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_width = 12'd1;
            reg_height = 16'd1;
            reg_plane = 12'd1;
            reg_mode = MODE_PALETTE;
            run_armed = 1'b0;
            run_count = '0;
            plane_sel = PLANE_RED;
            col_pos = '0;
            row_pos = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_IMAGE_WIDTH: begin
                        reg_width = i_cfg_data[11:0];
                    end
                    CFG_IMAGE_HEIGHT: begin
                        reg_height = i_cfg_data[15:0];
                    end
                    CFG_PLANE_BYTES: begin
                        reg_plane = i_cfg_data[11:0];
                    end
                    CFG_COLOR_MODE: begin
                        reg_mode = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[31:8],
                            s_axis_tdata[39:32]);
        end
    end

    // Sender: bursts of words separated by random gaps.
    always @(posedge i_clk) begin
        t_stream_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (words_pending.size() != 0) begin
                w = words_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {w.code, w.pal_rgb, w.pal_idx};
                s_axis_tuser <= w.action;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(16, 1);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: alternating ready and stall stretches, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            case ($urandom_range(3))
                0: begin
                    m_axis_tready <= 1'b0;
                    rx_left <= $urandom_range(4, 1);
                end
                3: begin
                    m_axis_tready <= 1'b1;
                    rx_left <= 60;
                end
                default: begin
                    m_axis_tready <= 1'b1;
                    rx_left <= $urandom_range(20, 1);
                end
            endcase
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch: %s got %0h want %0h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_pixel_exp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("pixel with none expected", 32'(m_axis_tdata), 32'd0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.px.red)
                    report_mismatch("red", 32'(m_axis_tdata[7:0]), 32'(want.px.red));
                if (m_axis_tdata[15:8] !== want.px.green)
                    report_mismatch("green", 32'(m_axis_tdata[15:8]), 32'(want.px.green));
                if (m_axis_tdata[23:16] !== want.px.blue)
                    report_mismatch("blue", 32'(m_axis_tdata[23:16]), 32'(want.px.blue));
                if (m_axis_tlast !== want.px.row_end)
                    report_mismatch("row_end", 32'(m_axis_tlast), 32'(want.px.row_end));
                if (m_axis_tuser[0] !== want.px.image_end)
                    report_mismatch("image_end", 32'(m_axis_tuser[0]),
                                    32'(want.px.image_end));
                if (m_axis_tuser[1] !== want.burst_last)
                    report_mismatch("burst_last", 32'(m_axis_tuser[1]),
                                    32'(want.burst_last));
            end
        end
    end

    function automatic void push_code(input logic [7:0] b);
        t_stream_word w;
        w.action = ACT_CODE;
        w.pal_idx = 8'($urandom);
        w.pal_rgb = 24'($urandom);
        w.code = b;
        words_pending.push_back(w);
    endfunction

    function automatic void push_palette(input logic [7:0] idx, input logic [23:0] rgb);
        t_stream_word w;
        w.action = ACT_PALETTE;
        w.pal_idx = idx;
        w.pal_rgb = rgb;
        w.code = 8'($urandom);
        words_pending.push_back(w);
    endfunction

    // Scanline bytes are drawn from the loaded palette entries only.
    function automatic logic [7:0] pick_lit();
        int unsigned r;
        r = $urandom_range(16);
        return (r == 16) ? 8'd191 : 8'(r);
    endfunction

    function automatic logic [7:0] pick_pix();
        return ($urandom_range(7) == 0) ? 8'd255 : pick_lit();
    endfunction

    // Wait until every word is taken and every pixel has come out, then give
    // the decoder time to finish a run tail that emits nothing.
    task automatic settle();
        @(negedge i_clk);
        while (words_pending.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Finish the current scanline so that three-plane mode starts on a clean
    // line and never reads a line buffer entry that was not written.
    task automatic align_line();
        int unsigned effp, n, k;
        while (run_armed || col_pos != 0 || plane_sel != PLANE_RED) begin
            if (run_armed) begin
                push_code(pick_pix());
            end else begin
                effp = eff_plane();
                n = (col_pos < effp) ? effp - col_pos : 1;
                if (reg_mode == MODE_RGB && plane_sel < PLANE_BLUE)
                    n += (PLANE_BLUE - plane_sel) * effp;
                while (n > 0) begin
                    k = (n > 63) ? 63 : n;
                    if (k == 1) begin
                        push_code(pick_lit());
                    end else begin
                        push_code(8'(192 + k));
                        push_code(pick_pix());
                    end
                    n -= k;
                end
            end
            settle();
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int w, input int h, input int p, input logic m);
        settle();
        if (m == MODE_RGB) align_line();
        write_reg(CFG_IMAGE_WIDTH, 16'(w));
        write_reg(CFG_IMAGE_HEIGHT, 16'(h));
        write_reg(CFG_PLANE_BYTES, 16'(p));
        write_reg(CFG_COLOR_MODE, 16'(m));
    endtask

    initial begin
        int ph, i, r, w, h, p;
        logic m;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every palette entry that a scanline byte can select.
        push_palette(8'd0, 24'h000000);
        for (i = 1; i < 16; i++)
            push_palette(8'(i), 24'($urandom_range(24'hFFFFFF)));
        push_palette(8'd191, 24'($urandom_range(24'hFFFFFF)));
        push_palette(8'd192, 24'($urandom_range(24'hFFFFFF)));
        push_palette(8'd255, 24'hFFFFFF);

        // Palette mode with two padding columns per row.
        set_regs(4, 2, 6, MODE_PALETTE);
        push_code(8'd0);
        push_code(8'd191);
        push_code(8'd255);
        push_code(8'd255);
        push_code(8'd192);
        push_code(8'd7);
        push_code(8'd194);
        push_palette(8'd3, 24'h123456);
        push_code(8'd192);
        push_code(8'd10);
        push_code(8'd11);

        // Width beyond the plane size.
        set_regs(8, 3, 3, MODE_PALETTE);
        push_code(8'd200);
        push_code(8'd5);

        // Zero width and zero plane size.
        set_regs(0, 1, 0, MODE_PALETTE);
        push_code(8'd5);
        push_code(8'd196);
        push_code(8'd9);

        // Largest width and plane size, height zero.
        set_regs(4095, 0, 4095, MODE_PALETTE);
        push_code(8'd255);
        push_code(8'd1);
        push_code(8'd2);

        // The column is past the new plane size and ends on the next byte.
        set_regs(6, 2, 6, MODE_PALETTE);
        push_code(8'd1);
        push_code(8'd2);
        push_code(8'd3);
        set_regs(6, 2, 2, MODE_PALETTE);
        push_code(8'd4);
        push_code(8'd5);

        // Three-plane line: red by a run, green by literals, blue by a run
        // followed by one padding byte.
        set_regs(3, 2, 4, MODE_RGB);
        push_code(8'd196);
        push_code(8'h11);
        push_code(8'h22);
        push_code(8'h23);
        push_code(8'h24);
        push_code(8'h25);
        push_code(8'd195);
        push_code(8'hFF);
        push_code(8'h80);
        // Stop halfway through the green plane, then fall back to palette mode
        // with the plane number left behind.
        push_code(8'd198);
        push_code(8'h40);
        set_regs(3, 2, 4, MODE_PALETTE);
        push_code(8'd9);
        push_code(8'd10);

        for (ph = 0; ph < 4; ph++) begin
            r = $urandom_range(99);
            w = (r < 10) ? 0 : (r < 20) ? 4095 : $urandom_range(10, 1);
            r = $urandom_range(99);
            h = (r < 10) ? 0 : (r < 20) ? 65535 : $urandom_range(5, 1);
            r = $urandom_range(99);
            p = (r < 10) ? 0 : $urandom_range(12, 1);
            m = (ph == 0) ? MODE_RGB : (ph == 1) ? MODE_PALETTE : 1'($urandom_range(1));
            set_regs(w, h, p, m);
            if (ph == 1) begin
                for (i = 0; i < 3; i++) begin
                    push_code(8'd255);
                    push_code(pick_pix());
                end
            end
            for (i = 0; i < 10; i++) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    push_palette(8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
                end else if (r < 55) begin
                    push_code(pick_lit());
                end else if (r < 90) begin
                    push_code(8'($urandom_range(255, 192)));
                    push_code(pick_pix());
                end else begin
                    push_code(pick_pix());
                end
            end
            if (ph == 1) begin
                // Long receiver hold-off while the sender keeps offering words.
                @(negedge i_clk);
                hold_req++;
            end
        end

        settle();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/pcxd_pkg.sv
rtl/pcxd_palette.sv
rtl/pcxd_linebuf.sv
rtl/pcxd_scan.sv
rtl/pcx_scanline_decoder.sv
test/tb_pcx_scanline_decoder.sv
